### rtl/core/sohdf_pkg.sv
// Package for the strip occupancy dead/noisy finder: payload structs,
// command codes and register indexes. No dependencies.
package sohdf_pkg;

    typedef enum logic [1:0] {
        CMD_HIT   = 2'd0,
        CMD_EVAL  = 2'd1,
        CMD_CHECK = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    localparam logic [0:0] REG_LOW_DIVISOR     = 1'd0;
    localparam logic [0:0] REG_HIGH_MULTIPLIER = 1'd1;
    localparam logic [7:0] LOW_DIVISOR_RESET     = 8'd5;
    localparam logic [7:0] HIGH_MULTIPLIER_RESET = 8'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  layer;
        logic [12:0] strip;
    } in_item_t;

    typedef struct packed {
        logic        flagged;
        logic        too_high;
        logic [19:0] median;
        logic [9:0]  nonzero_strips;
        logic        status;
    } out_item_t;

endpackage

### rtl/core/strip_occupancy_hot_dead_finder.sv
// Top level of the strip occupancy dead/noisy finder: APB registers plus
// front and back ends. Depends on sohdf_pkg, sohdf_front, sohdf_back.
//
//  channel   direction  handshake           payload
//  in        input      in_valid/in_ready   in_item_t (cmd, layer, strip)
//  out       output     out_valid/out_ready out_item_t
//  apb       input      psel/penable/pready low_divisor, high_multiplier
//
// Hit and check each pass a read state and a write or compare state in
// the back end, which reads the count memory through one port. Evaluate
// finds the median bit by bit, one board scan per count bit.
// After reset and after clear, a sweep writes zero to all
// LAYERS*BOARDS*STRIPS_PER_BOARD count entries; no item moves on meanwhile.
// A two-entry queue lets the front keep taking items while the back stalls.
module strip_occupancy_hot_dead_finder
    import sohdf_pkg::*;
#(
    parameter int LAYERS           = 8,
    parameter int BOARDS           = 16,
    parameter int STRIPS_PER_BOARD = 512,
    parameter int COUNT_BITS       = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [7:0] low_divisor_reg, high_multiplier_reg;
    logic       q_valid, q_ready, q_in_range;
    in_item_t   q_item;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_divisor_reg     <= LOW_DIVISOR_RESET;
            high_multiplier_reg <= HIGH_MULTIPLIER_RESET;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00)
        begin
            if (paddr[2] == REG_LOW_DIVISOR)
            begin
                low_divisor_reg <= pwdata[7:0];
            end
            else
            begin
                high_multiplier_reg <= pwdata[7:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[1:0] == 2'b00)
        begin
            prdata[7:0] = (paddr[2] == REG_LOW_DIVISOR) ? low_divisor_reg
                                                         : high_multiplier_reg;
        end
    end

    sohdf_front #(
        .LAYERS(LAYERS), .BOARDS(BOARDS), .STRIPS_PER_BOARD(STRIPS_PER_BOARD)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .in_item(in_item), .in_valid(in_valid),
        .in_ready(in_ready), .q_valid(q_valid), .q_ready(q_ready),
        .q_item(q_item), .q_in_range(q_in_range)
    );

    sohdf_back #(
        .LAYERS(LAYERS), .BOARDS(BOARDS), .STRIPS_PER_BOARD(STRIPS_PER_BOARD),
        .COUNT_BITS(COUNT_BITS)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
        .q_item(q_item), .q_in_range(q_in_range),
        .low_divisor(low_divisor_reg), .high_multiplier(high_multiplier_reg),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
    );
endmodule

### rtl/core/sohdf_front.sv
// Front end: accepts input items and classifies them into queue entries.
// Depends on sohdf_pkg.
module sohdf_front
    import sohdf_pkg::*;
#(
    parameter int LAYERS           = 8,
    parameter int BOARDS           = 16,
    parameter int STRIPS_PER_BOARD = 512
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  in_item_t in_item,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     q_valid,
    input  logic     q_ready,
    output in_item_t q_item,
    output logic     q_in_range
);
    // Two-entry queue toward the back end.
    in_item_t   ent_reg [2];
    logic       rng_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, rp_reg;
    logic       in_range;
    logic [12:0] board;
    logic       push, pop;

    assign board = 13'(in_item.strip / 13'(STRIPS_PER_BOARD));
    assign in_range = (32'(in_item.layer) < LAYERS) && (32'(board) < BOARDS);

    assign in_ready = (cnt_reg != 2'd2);
    assign push = in_valid && in_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop = q_valid && q_ready;
    assign q_item = ent_reg[rp_reg];
    assign q_in_range = rng_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wp_reg] <= in_item;
            rng_reg[wp_reg] <= in_range;
        end
    end
endmodule

### rtl/core/sohdf_back.sv
// Back end: count memory, clearing sweep, median search and strip check.
// Depends on sohdf_pkg.
module sohdf_back
    import sohdf_pkg::*;
#(
    parameter int LAYERS           = 8,
    parameter int BOARDS           = 16,
    parameter int STRIPS_PER_BOARD = 512,
    parameter int COUNT_BITS       = 20
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    output logic      q_ready,
    input  in_item_t  q_item,
    input  logic      q_in_range,
    input  logic [7:0] low_divisor,
    input  logic [7:0] high_multiplier,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);
    localparam int NB      = LAYERS * BOARDS;
    localparam int BB      = (NB > 1) ? $clog2(NB) : 1;
    localparam int OB      = $clog2(STRIPS_PER_BOARD);
    localparam int AB      = BB + OB;
    localparam int NC      = NB * STRIPS_PER_BOARD;
    localparam int NZB     = OB + 1;
    localparam int CB      = COUNT_BITS;
    localparam logic [CB-1:0] CMAX = {CB{1'b1}};

    typedef enum logic [8:0] {
        S_WIPE   = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_HRD    = 9'b000000100,
        S_HWR    = 9'b000001000,
        S_CRD    = 9'b000010000,
        S_CCMP   = 9'b000100000,
        S_ESCAN  = 9'b001000000,
        S_EDONE  = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [CB-1:0] mem [NC];
    logic [CB-1:0] rd_reg;
    logic [AB-1:0] rd_addr;
    logic          wr_en;
    logic [AB-1:0] wr_addr;
    logic [CB-1:0] wr_data;

    logic [CB-1:0] med_mem [NB];
    logic [NB-1:0] rdy_reg;

    in_item_t      it_reg;
    logic          clr_reg;
    logic [BB-1:0] bidx;
    logic [OB-1:0] offs;
    logic [AB:0]   wipe_reg;

    // Median search: bitwise over the count value, one scan of the board per
    // bit. cand is the prefix so far; below counts nonzero entries < trial.
    logic [$clog2(CB+1)-1:0] bit_reg;
    logic [CB-1:0] cand_reg;
    logic [OB:0]   scan_reg;
    logic [NZB-1:0] nz_reg, below_reg;
    logic          first_reg;
    logic [CB-1:0] trial;
    logic [OB-1:0] scan_idx;
    logic [OB:0]   scan_d_reg;
    logic          scan_v_reg;

    logic [CB+7:0] prod_low, prod_high;
    logic [CB-1:0] med_rd_reg;
    out_item_t     res_reg;

    assign bidx = BB'(32'(it_reg.layer) * BOARDS
                      + 32'(it_reg.strip) / STRIPS_PER_BOARD);
    assign offs = OB'(it_reg.strip);
    assign scan_idx = scan_reg[OB-1:0];
    assign trial = cand_reg | (CMAX & (CB'(1) << bit_reg));

    // Both products are taken once the count and the median are registered.
    assign prod_low  = (CB+8)'(rd_reg) * (CB+8)'(low_divisor);
    assign prod_high = (CB+8)'(med_rd_reg) * (CB+8)'(high_multiplier);

    assign q_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_item = res_reg;

    always_comb
    begin
        rd_addr = {bidx, offs};
        if (state_reg == S_ESCAN)
        begin
            rd_addr = {bidx, scan_idx};
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = {bidx, offs};
        wr_data = (rd_reg == CMAX) ? rd_reg : rd_reg + CB'(1);
        if (state_reg == S_WIPE)
        begin
            wr_en   = 1'b1;
            wr_addr = wipe_reg[AB-1:0];
            wr_data = '0;
        end
        else if (state_reg == S_HWR)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (32'(wr_addr) < NC))
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_WIPE:
            begin
                // A clear answers once the sweep is over; the sweep after
                // reset has nothing to answer.
                if (32'(wipe_reg) == NC - 1)
                begin
                    state_next = clr_reg ? S_OUT : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.cmd == CMD_CLEAR)
                    begin
                        state_next = S_WIPE;
                    end
                    else if (!q_in_range)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        unique case (cmd_t'(q_item.cmd))
                            CMD_HIT:   state_next = S_HRD;
                            CMD_EVAL:  state_next = S_ESCAN;
                            CMD_CHECK: state_next = S_CRD;
                            default:   state_next = S_OUT;
                        endcase
                    end
                end
            end
            S_HRD:   state_next = S_HWR;
            S_HWR:   state_next = S_OUT;
            S_CRD:   state_next = S_CCMP;
            S_CCMP:  state_next = S_OUT;
            S_ESCAN:
            begin
                if (scan_d_reg[OB] && !scan_v_reg)
                begin
                    state_next = S_EDONE;
                end
            end
            S_EDONE:
            begin
                if (first_reg && nz_reg == '0)
                begin
                    state_next = S_OUT;
                end
                else if (bit_reg == '0)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_ESCAN;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_WIPE;
            wipe_reg  <= '0;
            rdy_reg   <= '0;
            clr_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_WIPE)
            begin
                wipe_reg <= wipe_reg + 1'b1;
            end
            else
            begin
                wipe_reg <= '0;
            end
            if (state_reg == S_IDLE && q_valid && q_item.cmd == CMD_CLEAR)
            begin
                clr_reg <= 1'b1;
            end
            else if (state_reg == S_OUT)
            begin
                clr_reg <= 1'b0;
            end
            if (state_reg == S_IDLE && q_valid && q_item.cmd == CMD_CLEAR)
            begin
                rdy_reg <= '0;
            end
            else if (state_reg == S_EDONE && bit_reg == '0
                     && !(first_reg && nz_reg == '0))
            begin
                rdy_reg[bidx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                it_reg     <= q_item;
                res_reg    <= '{flagged: 1'b0, too_high: 1'b0, median: '0,
                                nonzero_strips: '0,
                                status: !q_in_range && q_item.cmd != CMD_CLEAR};
                bit_reg    <= ($clog2(CB+1))'(CB - 1);
                cand_reg   <= '0;
                scan_reg   <= '0;
                scan_v_reg <= 1'b0;
                scan_d_reg <= '0;
                nz_reg     <= '0;
                below_reg  <= '0;
                first_reg  <= 1'b1;
            end
            S_CRD:
            begin
                med_rd_reg <= rdy_reg[bidx] ? med_mem[bidx] : '0;
            end
            S_CCMP:
            begin
                res_reg.median <= 20'(med_rd_reg);
                if (!rdy_reg[bidx])
                begin
                    res_reg.status <= 1'b1;
                end
                else
                begin
                    res_reg.too_high <= (CB+8)'(rd_reg) > prod_high;
                    res_reg.flagged  <= (prod_low < (CB+8)'(med_rd_reg))
                                        || ((CB+8)'(rd_reg) > prod_high);
                end
            end
            S_ESCAN:
            begin
                // Read pipeline: address issued, data in the cycle after.
                if (!scan_reg[OB])
                begin
                    scan_reg <= scan_reg + 1'b1;
                end
                scan_v_reg <= !scan_reg[OB];
                scan_d_reg <= scan_reg;
                if (scan_v_reg && rd_reg != '0)
                begin
                    if (first_reg)
                    begin
                        nz_reg <= nz_reg + 1'b1;
                    end
                    if (rd_reg < trial)
                    begin
                        below_reg <= below_reg + 1'b1;
                    end
                end
            end
            S_EDONE:
            begin
                // Element at index n/2 is >= trial iff fewer than n/2+1 are below.
                if (first_reg)
                begin
                    if (below_reg <= (nz_reg >> 1))
                    begin
                        cand_reg <= trial;
                    end
                end
                else if (below_reg <= (nz_reg >> 1))
                begin
                    cand_reg <= trial;
                end
                first_reg  <= 1'b0;
                below_reg  <= '0;
                scan_reg   <= '0;
                scan_v_reg <= 1'b0;
                scan_d_reg <= '0;
                if (bit_reg != '0)
                begin
                    bit_reg <= bit_reg - 1'b1;
                end
                res_reg.nonzero_strips <= 10'(nz_reg);
                if (first_reg && nz_reg == '0)
                begin
                    res_reg.status <= 1'b1;
                    res_reg.median <= 20'(rdy_reg[bidx] ? med_mem[bidx] : '0);
                end
                else if (bit_reg == '0)
                begin
                    res_reg.median <= 20'((below_reg <= (nz_reg >> 1))
                                          ? trial : cand_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Median store; entries of unevaluated boards are masked by rdy_reg.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_EDONE && bit_reg == '0 && !(first_reg && nz_reg == '0))
        begin
            med_mem[bidx] <= (below_reg <= (nz_reg >> 1)) ? trial : cand_reg;
        end
    end
endmodule
